>>> hdl/mts_pkg.sv
// Shared types and constants for the melody tone sequencer.
// Holds the command and result words, kind and clock select codes and the compare ROM.
// No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

	localparam int TUNE_DEPTH_DEF = 256;
	localparam int NOTE_COUNT = 128;

	// Command kinds.
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_LOAD  = 3'd1;
	localparam logic [2:0] KIND_PLAY  = 3'd2;
	localparam logic [2:0] KIND_PAUSE = 3'd3;
	localparam logic [2:0] KIND_STOP  = 3'd4;

	// Timer clock selects.
	localparam logic [2:0] CS_STOP   = 3'd0;
	localparam logic [2:0] CS_DIV1   = 3'd1;
	localparam logic [2:0] CS_DIV8   = 3'd2;
	localparam logic [2:0] CS_DIV64  = 3'd3;
	localparam logic [2:0] CS_DIV256 = 3'd4;

	// Register word index on the configuration port.
	localparam logic REG_REST_CODE = 1'b0;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] entry_index;
		logic [7:0] entry_note;
		logic [7:0] entry_duration;
		logic [7:0] tune_start;
		logic [7:0] tune_length;
	} cmd_word_t;

	typedef struct packed {
		logic       timer_update;
		logic [2:0] clock_select;
		logic       compare_write;
		logic [7:0] compare_value;
		logic       bad_note;
	} res_word_t;

	localparam logic [7:0] CMP_ROM [NOTE_COUNT] = '{
		8'd238, 8'd224, 8'd212, 8'd200, 8'd189, 8'd178, 8'd168, 8'd158,
		8'd149, 8'd141, 8'd133, 8'd126, 8'd118, 8'd112, 8'd105, 8'd99,
		8'd94,  8'd88,  8'd83,  8'd79,  8'd74,  8'd70,  8'd66,
		8'd252, 8'd238, 8'd224, 8'd212, 8'd200, 8'd189, 8'd178, 8'd168,
		8'd158, 8'd149, 8'd141, 8'd133, 8'd126, 8'd118, 8'd112, 8'd105,
		8'd99,  8'd94,  8'd88,  8'd83,  8'd79,  8'd74,  8'd70,  8'd66,
		8'd62,  8'd59,  8'd55,  8'd52,  8'd49,  8'd46,  8'd44,  8'd41,
		8'd39,  8'd37,  8'd35,  8'd33,  8'd31,  8'd29,
		8'd224, 8'd212, 8'd200, 8'd189, 8'd178, 8'd168, 8'd158, 8'd149,
		8'd141, 8'd133, 8'd126, 8'd118, 8'd112, 8'd105, 8'd99,  8'd94,
		8'd88,  8'd83,  8'd79,  8'd74,  8'd70,  8'd66,
		8'd62,  8'd59,  8'd55,  8'd52,  8'd49,  8'd46,  8'd44,  8'd41,
		8'd39,  8'd37,  8'd35,  8'd33,
		8'd252, 8'd238, 8'd224, 8'd212, 8'd200, 8'd189, 8'd178, 8'd168,
		8'd158, 8'd149, 8'd141, 8'd133, 8'd126, 8'd118, 8'd112, 8'd105,
		8'd99,  8'd94,  8'd88,  8'd83,  8'd79,  8'd74,  8'd70,  8'd66,
		8'd62,  8'd59,  8'd55,  8'd52,  8'd49,  8'd46,  8'd44,  8'd41,
		8'd39
	};

endpackage

>>> hdl/mts_tone_decode.sv
// Note decoder: turns a stored note number into a timer programming word.
// Depends on mts_pkg for the result word, clock select codes and compare ROM.
`timescale 1ns / 1ps

module mts_tone_decode
	import mts_pkg::*;
(
	input  logic [7:0] note,
	input  logic [7:0] rest_code,
	output res_word_t  tone
);

	function automatic logic [2:0] clock_for(input logic [7:0] n);
		if (n < 8'd23) return CS_DIV256;
		if (n < 8'd61) return CS_DIV64;
		if (n < 8'd95) return CS_DIV8;
		return CS_DIV1;
	endfunction

	// The rest code and out-of-range notes both silence the timer.
	always_comb begin
		tone = '0;
		tone.timer_update = 1'b1;
		if (note != rest_code) begin
			if (note < 8'(NOTE_COUNT)) begin
				tone.clock_select  = clock_for(note);
				tone.compare_write = 1'b1;
				tone.compare_value = CMP_ROM[note[6:0]];
			end else begin
				tone.bad_note = 1'b1;
			end
		end
	end

endmodule

>>> hdl/melody_tone_sequencer.sv
// Top level of the melody tone sequencer: command pipeline, tune store and register port.
// Depends on mts_pkg and mts_tone_decode.
`timescale 1ns / 1ps
//
//  Channel   Handshake              Word        Direction
//  command   cmd_valid / cmd_ready  cmd         in
//  result    res_valid / res_ready  res         out
//  config    psel / penable / pready (APB)      in, reads back rest_code
//
//  One command word is taken every cycle while cmd_ready is high; it passes stage one to res.
//  The tune store is read when a command is taken, with the address that the command
//  ahead of it leaves, so ticks follow each other without a bubble.
//  Reset needs no clearing pass; the tune store is undefined until loaded.
//  A stalled result holds the pipeline; cmd_ready drops only while both stages are full.

module melody_tone_sequencer
	import mts_pkg::*;
#(
	parameter int TUNE_DEPTH = TUNE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_word_t   cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output res_word_t   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(TUNE_DEPTH);

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_PAUSED  = 2'd1,
		MODE_PLAYING = 2'd2
	} mode_t;

	// Reduce an 8-bit address modulo the store depth by restoring subtraction.
	function automatic logic [AW-1:0] mod_depth(input logic [7:0] x);
		logic [11:0] r;
		r = {4'b0, x};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (12'(TUNE_DEPTH) << k)) r = r - (12'(TUNE_DEPTH) << k);
		end
		return r[AW-1:0];
	endfunction

	mode_t       mode_q, mode_d;
	logic [7:0]  step_q, step_d;
	logic [7:0]  len_q, len_d;
	logic [AW-1:0] base_q, base_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [7:0]  hold_q, hold_d;
	logic [7:0]  rest_q;

	logic        valid_s1;
	cmd_word_t   cmd_s1;
	logic [15:0] ent_s1;

	logic        res_valid_q;
	res_word_t   res_q, res_d;
	res_word_t   tone;

	logic        s1_fire, cmd_fire;
	logic [8:0]  nxt, wrap;
	logic [AW-1:0] addr_inc;
	logic [AW-1:0] wr_addr;

	logic [15:0] store [TUNE_DEPTH];

	assign s1_fire   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || s1_fire;
	assign cmd_fire  = cmd_valid && cmd_ready;

	assign nxt      = {1'b0, step_q} + 9'd1;
	assign wrap     = (len_q == 8'd0) ? 9'(TUNE_DEPTH) : {1'b0, len_q};
	assign addr_inc = (addr_q == AW'(TUNE_DEPTH - 1)) ? '0 : addr_q + AW'(1);
	assign wr_addr  = mod_depth(cmd.entry_index);

	mts_tone_decode u_decode (
		.note      (ent_s1[15:8]),
		.rest_code (rest_q),
		.tone      (tone)
	);

	// State update for the command in stage one. addr tracks (base + step) mod depth.
	always_comb begin
		mode_d = mode_q;
		step_d = step_q;
		len_d  = len_q;
		base_d = base_q;
		addr_d = addr_q;
		hold_d = hold_q;
		res_d  = '0;
		if (s1_fire) begin
			unique case (cmd_s1.kind)
				KIND_TICK: begin
					if (mode_q == MODE_PLAYING) begin
						if (hold_q == 8'd0) begin
							res_d  = tone;
							hold_d = ent_s1[7:0];
							if (nxt == wrap) begin
								step_d = '0;
								addr_d = base_q;
							end else begin
								step_d = nxt[7:0];
								addr_d = addr_inc;
							end
						end else begin
							hold_d = hold_q - 8'd1;
						end
					end
				end
				KIND_PLAY: begin
					step_d = '0;
					len_d  = cmd_s1.tune_length;
					base_d = mod_depth(cmd_s1.tune_start);
					addr_d = mod_depth(cmd_s1.tune_start);
					mode_d = MODE_PLAYING;
				end
				KIND_PAUSE: begin
					mode_d = MODE_PAUSED;
				end
				KIND_STOP: begin
					step_d = '0;
					addr_d = base_q;
					mode_d = MODE_STOPPED;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PAUSED;
			step_q      <= '0;
			len_q       <= '0;
			base_q      <= '0;
			addr_q      <= '0;
			hold_q      <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			step_q <= step_d;
			len_q  <= len_d;
			base_q <= base_d;
			addr_q <= addr_d;
			hold_q <= hold_d;
			if (cmd_ready) valid_s1 <= cmd_valid;
			if (s1_fire) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) cmd_s1 <= cmd;
		if (s1_fire) res_q <= res_d;
	end

	// A load writes its entry and any other taken command reads, so one port serves both.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			if (cmd.kind == KIND_LOAD) store[wr_addr] <= {cmd.entry_note, cmd.entry_duration};
			else ent_s1 <= store[addr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= 8'hff;
		end else if (psel && penable && pwrite && (paddr[2] == REG_REST_CODE)) begin
			rest_q <= pwdata[7:0];
		end
	end

	assign prdata    = (paddr[2] == REG_REST_CODE) ? {24'b0, rest_q} : 32'b0;
	assign pready    = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> tb/melody_tone_sequencer_tb.sv
// Self-checking testbench for melody_tone_sequencer: command words in, tone timer words out.
// A local tone predictor builds the expected word for every accepted command word.
// Depends on mts_pkg and the melody_tone_sequencer RTL.
`timescale 1ns / 1ps

module melody_tone_sequencer_tb;
	import mts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int LONG_HOLD_AFTER = 400;
	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

	// Notes on both sides of each divider boundary, plus the rest code and a bad note.
	localparam logic [7:0] BOUNDARY_NOTES [10] = '{0, 22, 23, 60, 61, 94, 95, 127, 255, 128};
	localparam logic [7:0] PHASE_REST [3] = '{8'd0, 8'd127, 8'd255};
	localparam int PHASE_SEND_IDLE [3] = '{72, 0, 10};
	localparam int PHASE_RECV_STALL [3] = '{0, 72, 10};

	localparam logic [7:0] TONE_CMP [128] = '{
		238, 224, 212, 200, 189, 178, 168, 158, 149, 141, 133, 126, 118, 112, 105, 99,
		94, 88, 83, 79, 74, 70, 66,
		252, 238, 224, 212, 200, 189, 178, 168, 158, 149, 141, 133, 126, 118, 112, 105,
		99, 94, 88, 83, 79, 74, 70, 66,
		62, 59, 55, 52, 49, 46, 44, 41, 39, 37, 35, 33, 31, 29,
		224, 212, 200, 189, 178, 168, 158, 149, 141, 133, 126, 118, 112, 105, 99, 94,
		88, 83, 79, 74, 70, 66,
		62, 59, 55, 52, 49, 46, 44, 41, 39, 37, 35, 33,
		252, 238, 224, 212, 200, 189, 178, 168, 158, 149, 141, 133, 126, 118, 112, 105,
		99, 94, 88, 83, 79, 74, 70, 66,
		62, 59, 55, 52, 49, 46, 44, 41, 39
	};

	typedef enum logic [1:0] {MODE_STOPPED, MODE_PAUSED, MODE_PLAYING} play_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_word_t   cmd = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_word_t   res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Tone predictor state.
	logic [7:0]  rest_note = 8'd255;
	play_state_t play_state = MODE_PAUSED;
	logic [7:0]  step_pos = '0;
	logic [7:0]  tune_span = '0;
	logic [7:0]  tune_origin = '0;
	logic [7:0]  hold_left = '0;
	logic [15:0] tune_mem [TUNE_DEPTH_DEF];

	cmd_word_t   pending_cmds [$];
	res_word_t   tone_expect_q [$];
	res_word_t   tone_want;
	int          queued_total = 0;
	int          results_seen = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_off_left = 0;
	bit          long_hold_done = 1'b0;
	bit          cmd_fire = 1'b0;

	melody_tone_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void flag_error(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic string tone_text(input res_word_t r);
		return $sformatf("upd=%0b cs=%0d cw=%0b cv=%0d bad=%0b", r.timer_update,
			r.clock_select, r.compare_write, r.compare_value, r.bad_note);
	endfunction

	// Advances the predictor by one command word and returns the tone word it causes.
	function automatic res_word_t predict_tone(input cmd_word_t c);
		res_word_t   r;
		logic [15:0] ent;
		logic [7:0]  note;
		int          wrap;
		int          nxt;
		r = '0;
		case (c.kind)
			KIND_TICK: begin
				if (play_state == MODE_PLAYING) begin
					if (hold_left == 0) begin
						ent = tune_mem[(int'(tune_origin) + int'(step_pos)) % TUNE_DEPTH_DEF];
						note = ent[15:8];
						r.timer_update = 1'b1;
						if (note != rest_note && note < NOTE_COUNT) begin
							if (note < 23) r.clock_select = CS_DIV256;
							else if (note < 61) r.clock_select = CS_DIV64;
							else if (note < 95) r.clock_select = CS_DIV8;
							else r.clock_select = CS_DIV1;
							r.compare_write = 1'b1;
							r.compare_value = TONE_CMP[note[6:0]];
						end else if (note != rest_note) begin
							r.bad_note = 1'b1;
						end
						hold_left = ent[7:0];
						wrap = (tune_span == 0) ? TUNE_DEPTH_DEF : int'(tune_span);
						nxt = int'(step_pos) + 1;
						if (nxt == wrap) nxt = 0;
						step_pos = 8'(nxt);
					end else begin
						hold_left = hold_left - 8'd1;
					end
				end
			end
			KIND_LOAD: begin
				tune_mem[c.entry_index] = {c.entry_note, c.entry_duration};
			end
			KIND_PLAY: begin
				step_pos = '0;
				tune_span = c.tune_length;
				tune_origin = c.tune_start;
				play_state = MODE_PLAYING;
			end
			KIND_PAUSE: begin
				play_state = MODE_PAUSED;
			end
			KIND_STOP: begin
				step_pos = '0;
				play_state = MODE_STOPPED;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Fields a command does not use still carry random bits.
	function automatic cmd_word_t random_cmd(input logic [2:0] k);
		cmd_word_t w;
		w.kind = k;
		w.entry_index = 8'($urandom);
		w.entry_note = 8'($urandom);
		w.entry_duration = 8'($urandom);
		w.tune_start = 8'($urandom);
		w.tune_length = 8'($urandom);
		return w;
	endfunction

	function automatic void queue_cmd(input cmd_word_t w);
		pending_cmds.push_back(w);
		queued_total++;
	endfunction

	function automatic void queue_simple(input logic [2:0] k);
		queue_cmd(random_cmd(k));
	endfunction

	function automatic void queue_load(input logic [7:0] idx, input logic [7:0] note,
		input logic [7:0] dur);
		cmd_word_t w;
		w = random_cmd(KIND_LOAD);
		w.entry_index = idx;
		w.entry_note = note;
		w.entry_duration = dur;
		queue_cmd(w);
	endfunction

	function automatic void queue_play(input logic [7:0] origin, input logic [7:0] span);
		cmd_word_t w;
		w = random_cmd(KIND_PLAY);
		w.tune_start = origin;
		w.tune_length = span;
		queue_cmd(w);
	endfunction

	function automatic logic [7:0] pick_note();
		int s;
		s = $urandom_range(99);
		if (s < 60) return 8'($urandom_range(127));
		if (s < 75) return rest_note;
		return 8'($urandom_range(255, 128));
	endfunction

	// Mostly short holds so that tunes move on and wrap within a session.
	function automatic logic [7:0] pick_hold();
		int s;
		s = $urandom_range(99);
		if (s < 70) return 8'($urandom_range(3));
		if (s < 95) return 8'($urandom_range(20, 4));
		return 8'($urandom_range(255));
	endfunction

	function automatic void queue_disturbance();
		case ($urandom_range(4))
			0: queue_simple(KIND_PAUSE);
			1: queue_simple(KIND_STOP);
			2: queue_simple(3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO)));
			3: queue_play(8'($urandom), 8'($urandom));
			default: queue_load(8'($urandom), pick_note(), pick_hold());
		endcase
	endfunction

	// Mostly load-play-tick sessions with random content, the rest tick bursts and noise.
	// Every store entry is written before this runs, so any play is safe.
	function automatic void queue_random_traffic(input int n);
		int         goal;
		int         sel;
		int         count;
		logic [7:0] origin;
		logic [7:0] span;
		goal = queued_total + n;
		while (queued_total < goal) begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				origin = 8'($urandom);
				sel = $urandom_range(99);
				if (sel < 70) span = 8'($urandom_range(8, 1));
				else if (sel < 85) span = '0;
				else span = 8'($urandom_range(255, 9));
				count = $urandom_range(6);
				for (int i = 0; i < count; i++) begin
					queue_load(origin + 8'(i), pick_note(), pick_hold());
				end
				queue_play(origin, span);
				count = $urandom_range(40, 4);
				for (int i = 0; i < count; i++) begin
					if ($urandom_range(99) < 6) queue_disturbance();
					else queue_simple(KIND_TICK);
				end
			end else if (sel < 85) begin
				count = $urandom_range(16, 1);
				for (int i = 0; i < count; i++) begin
					queue_simple(KIND_TICK);
				end
			end else begin
				queue_disturbance();
			end
		end
	endfunction

	task automatic rest_code_access(input bit do_write, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= do_write;
		paddr <= {REG_REST_CODE, 2'b00};
		pwdata <= {24'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (do_write) begin
			rest_note = value;
		end else if (prdata[7:0] !== rest_note) begin
			flag_error($sformatf("rest_code read: expected %0d, got %0d", rest_note,
				prdata[7:0]));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || cmd_valid || tone_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_fire)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// One long hold-off while the sender keeps offering, so the pipeline fills up.
	always @(negedge clk) begin
		if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			res_ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
			long_hold_done <= 1'b1;
			hold_off_left <= LONG_HOLD_CYCLES;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cmd_fire = arst_n && cmd_valid && cmd_ready;
		if (cmd_fire) begin
			tone_expect_q.push_back(predict_tone(cmd));
		end
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (tone_expect_q.size() == 0) begin
				flag_error($sformatf("tone word with none expected: %s", tone_text(res)));
			end else begin
				tone_want = tone_expect_q.pop_front();
				if (res.timer_update !== tone_want.timer_update ||
					res.clock_select !== tone_want.clock_select ||
					res.compare_write !== tone_want.compare_write ||
					res.compare_value !== tone_want.compare_value ||
					res.bad_note !== tone_want.bad_note) begin
					flag_error($sformatf("tone word %0d: expected %s, got %s", results_seen,
						tone_text(tone_want), tone_text(res)));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		rest_code_access(1'b0, 8'h00);

		// Tick while paused after reset, then the unused kinds.
		queue_simple(KIND_TICK);
		queue_simple(KIND_UNUSED_LO);
		queue_simple(KIND_UNUSED_HI);
		// A short tune across the top of the store, wrapping to address 0.
		for (int i = 0; i < 10; i++) begin
			queue_load(8'(254 + i), BOUNDARY_NOTES[i], (i == 1) ? 8'd1 : 8'd0);
		end
		queue_play(8'd254, 8'd10);
		for (int i = 0; i < 12; i++) begin
			queue_simple(KIND_TICK);
		end
		queue_simple(KIND_PAUSE);
		queue_simple(KIND_TICK);
		queue_simple(KIND_STOP);
		queue_simple(KIND_TICK);
		// Fill the whole store before any random play.
		for (int i = 0; i < TUNE_DEPTH_DEF; i++) begin
			queue_load(8'(i), pick_note(), pick_hold());
		end
		queue_random_traffic(400);
		drain();

		for (int p = 0; p < 3; p++) begin
			rest_code_access(1'b1, PHASE_REST[p]);
			rest_code_access(1'b0, 8'h00);
			send_idle_pct = PHASE_SEND_IDLE[p];
			recv_stall_pct = PHASE_RECV_STALL[p];
			queue_random_traffic(430);
			drain();
		end

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
